FILE: rtl/core/multi_shape_oscillator_assert.svh
// Assertion macros used by the oscillator top level.
`ifndef MULTI_SHAPE_OSCILLATOR_ASSERT_SVH
`define MULTI_SHAPE_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSOSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillator check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MSOSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oscillator check failed: next-cycle implication");

`endif

FILE: rtl/core/msosc_pkg.sv
`timescale 1ns / 1ps
// Shared codes, constants and inter-stage types of the multi-shape oscillator.
package msosc_pkg;

    // waveform codes
    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SHAPE     = 2'd0;
    localparam logic [1:0] REG_FREQ      = 2'd1;
    localparam logic [1:0] REG_PHASE     = 2'd2;
    localparam logic [1:0] REG_AMPLITUDE = 2'd3;

    localparam logic [15:0] AMPLITUDE_RESET = 16'h8000;

    // quarter-wave sine table generation, Q30 Taylor series
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam longint unsigned ROUND_Q30    = 64'd536870912;
    localparam int              TAYLOR_TERMS = 7;
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // output magnitude limit and positive clamp
    localparam logic [17:0]        MAG_LIMIT  = 18'd32768;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

    typedef struct packed {
        logic        valid;
        logic [31:0] phase;
    } ph_bus_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } shp_ctl_t;

endpackage

FILE: rtl/core/msosc_phase.sv
`timescale 1ns / 1ps
// Phase stages: input register, time times frequency, phase offset subtract.
module msosc_phase (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [31:0]          time_ticks,
    input  logic [31:0]          freq_word,
    input  logic [15:0]          phase_offset,
    output msosc_pkg::ph_bus_t   ph
);

    logic        a_valid_reg;
    logic [31:0] a_time_reg;
    logic        b_valid_reg;
    logic [31:0] b_prod_reg;
    logic        c_valid_reg;
    logic [31:0] c_phase_reg;

    logic [63:0] prod_full;
    logic [31:0] prod_next;
    logic [31:0] phase_next;

    assign prod_full  = 64'(a_time_reg) * 64'(freq_word);
    assign prod_next  = prod_full[31:0];
    // wraps modulo one cycle
    assign phase_next = b_prod_reg - {phase_offset, 16'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_time_reg  <= time_ticks;
            b_prod_reg  <= prod_next;
            c_phase_reg <= phase_next;
        end
    end

    assign ph.valid = c_valid_reg;
    assign ph.phase = c_phase_reg;

endmodule

FILE: rtl/core/msosc_shape.sv
`timescale 1ns / 1ps
// Shape stages: waveform select and quarter-wave sine table lookup.
module msosc_shape #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  msosc_pkg::ph_bus_t      ph,
    input  logic [1:0]              shape_select,
    output msosc_pkg::shp_ctl_t     ctl,
    output logic [SAMPLE_BITS-1:0]  mag
);

    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDX_PROD_W = 30 + IDX_W;
    localparam int TRI_W      = SAMPLE_BITS + 1;

    localparam logic [IDX_W-1:0]       DEPTH_IDX  = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [TRI_W-1:0]       TRI_FS     = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [TRI_W-1:0]       TRI_2FS    = {2'b10, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [TRI_W-1:0]       TRI_3FS    = {2'b11, {(SAMPLE_BITS-1){1'b0}}};
    localparam longint unsigned        FS_WIDE    = 64'd1 << (SAMPLE_BITS - 1);

    typedef logic [SAMPLE_BITS-1:0] rom_t [0:SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t            tbl;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            a    = (64'(i) * msosc_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            a2   = (a * a) >> 30;
            term = a;
            sum  = longint'(a);
            for (int k = 1; k <= msosc_pkg::TAYLOR_TERMS; k++) begin
                term = ((term * a2) >> 30) / msosc_pkg::TAYLOR_DIV[k];
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = ((64'(sum) << (SAMPLE_BITS - 1)) + msosc_pkg::ROUND_Q30) >> 30;
            if (v > FS_WIDE) begin
                v = FS_WIDE;
            end
            tbl[i] = SAMPLE_BITS'(v);
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]             quad;
    logic [IDX_PROD_W-1:0]  idx_prod;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       addr_next;
    logic [TRI_W-1:0]       tri_u;
    logic [TRI_W-1:0]       tri_down;
    logic [TRI_W-1:0]       tri_up;
    logic [TRI_W-1:0]       tri_wrap;
    logic [SAMPLE_BITS-1:0] saw_low;
    logic [SAMPLE_BITS-1:0] mag_next;
    logic                   neg_next;

    logic                   d_valid_reg;
    logic                   d_neg_reg;
    logic                   d_sine_reg;
    logic [SAMPLE_BITS-1:0] d_mag_reg;
    logic [IDX_W-1:0]       d_addr_reg;

    logic                   e_valid_reg;
    logic                   e_neg_reg;
    logic                   e_sine_reg;
    logic [SAMPLE_BITS-1:0] e_mag_reg;
    logic [SAMPLE_BITS-1:0] e_rom_reg;

    assign quad      = ph.phase[31:30];
    assign idx_prod  = IDX_PROD_W'(ph.phase[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign idx       = idx_prod[IDX_PROD_W-1:30];
    // mirror the table in the second and fourth quarters
    assign addr_next = quad[0] ? (DEPTH_IDX - idx) : idx;

    assign tri_u    = ph.phase[31 -: TRI_W];
    assign tri_down = TRI_2FS - tri_u;
    assign tri_up   = tri_u - TRI_2FS;
    assign tri_wrap = ~tri_u + TRI_W'(1);
    assign saw_low  = SAMPLE_BITS'(ph.phase[30 -: (SAMPLE_BITS - 1)]);

    always_comb begin
        mag_next = '0;
        neg_next = 1'b0;
        unique case (shape_select)
            msosc_pkg::SHAPE_SINE: begin
                neg_next = quad[1];
            end
            msosc_pkg::SHAPE_SQUARE: begin
                mag_next = FULL_SCALE;
                neg_next = (ph.phase > 32'h8000_0000);
            end
            msosc_pkg::SHAPE_TRIANGLE: begin
                priority if (tri_u <= TRI_FS) begin
                    mag_next = tri_u[SAMPLE_BITS-1:0];
                end else if (tri_u <= TRI_2FS) begin
                    mag_next = tri_down[SAMPLE_BITS-1:0];
                end else if (tri_u <= TRI_3FS) begin
                    mag_next = tri_up[SAMPLE_BITS-1:0];
                    neg_next = 1'b1;
                end else begin
                    mag_next = tri_wrap[SAMPLE_BITS-1:0];
                    neg_next = 1'b1;
                end
            end
            msosc_pkg::SHAPE_SAWTOOTH: begin
                // lower half of the phase (bit 31 clear) is the positive ramp
                if (!ph.phase[31]) begin
                    mag_next = saw_low;
                end else begin
                    mag_next = FULL_SCALE - saw_low;
                    neg_next = 1'b1;
                end
            end
            default: begin
                mag_next = '0;
                neg_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= ph.valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_neg_reg  <= neg_next;
            d_sine_reg <= (shape_select == msosc_pkg::SHAPE_SINE);
            d_mag_reg  <= mag_next;
            d_addr_reg <= addr_next;
            e_neg_reg  <= d_neg_reg;
            e_sine_reg <= d_sine_reg;
            e_mag_reg  <= d_mag_reg;
            e_rom_reg  <= SINE_ROM[d_addr_reg];
        end
    end

    assign ctl.valid = e_valid_reg;
    assign ctl.neg   = e_neg_reg;
    assign mag       = e_sine_reg ? e_rom_reg : e_mag_reg;

endmodule

FILE: rtl/core/msosc_scale.sv
`timescale 1ns / 1ps
// Scale stages: amplitude multiply, rounding, sign and saturation to 16 bits.
module msosc_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  msosc_pkg::shp_ctl_t     ctl,
    input  logic [SAMPLE_BITS-1:0]  mag,
    input  logic [15:0]             amplitude,
    output logic                    out_valid,
    output logic signed [15:0]      out_sample
);

    localparam int PROD_W = SAMPLE_BITS + 16;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SAMPLE_BITS - 2);

    logic                    f_valid_reg;
    logic                    f_neg_reg;
    logic [PROD_W-1:0]       f_prod_reg;
    logic                    g_valid_reg;
    logic signed [15:0]      g_sample_reg;

    logic [PROD_W-1:0]       prod_next;
    logic [SUM_W-1:0]        round_sum;
    logic [17:0]             mag_round;
    logic [17:0]             mag_sat;
    logic [17:0]             mag_neg;
    logic signed [15:0]      sample_next;

    assign prod_next = PROD_W'(mag) * PROD_W'(amplitude);
    assign round_sum = SUM_W'(f_prod_reg) + ROUND_HALF;
    assign mag_round = round_sum[SUM_W-1:SAMPLE_BITS-1];
    assign mag_sat   = (mag_round > msosc_pkg::MAG_LIMIT) ? msosc_pkg::MAG_LIMIT : mag_round;
    assign mag_neg   = ~mag_sat + 18'd1;

    always_comb begin
        if (f_neg_reg) begin
            sample_next = signed'(mag_neg[15:0]);
        end else if (mag_sat == msosc_pkg::MAG_LIMIT) begin
            // positive full scale clamps
            sample_next = msosc_pkg::SAMPLE_MAX;
        end else begin
            sample_next = signed'(mag_sat[15:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= ctl.valid;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_neg_reg    <= ctl.neg;
            f_prod_reg   <= prod_next;
            g_sample_reg <= sample_next;
        end
    end

    assign out_valid  = g_valid_reg;
    assign out_sample = g_sample_reg;

endmodule

FILE: rtl/core/multi_shape_oscillator.sv
`timescale 1ns / 1ps
// Multi-shape oscillator top level: config registers and the seven-stage sample pipeline.
//
//   port group | dir | payload
//   s_         | in  | time_ticks, one transaction per sample
//   m_         | out | sample, one transaction per input transaction
//   cfg_       | in  | register index and write data
//
// One sample per cycle while the output is not stalled; stages a, b, c (phase), d, e (shape), f, g (scale).
// Every stage advances together when the output register is empty or being taken,
// so a stall holds the whole pipeline in place and s_tready equals that advance condition.
// Synchronous active-low reset clears the valid bits and loads the config registers' reset values.
// The sine table is a constant ROM; no clearing pass is needed after reset.
`include "multi_shape_oscillator_assert.svh"

module multi_shape_oscillator #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] time_ticks
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [1:0]  shape_sel_reg;
    logic [31:0] freq_word_reg;
    logic [15:0] phase_offset_reg;
    logic [15:0] amplitude_reg;

    logic                    adv;
    msosc_pkg::ph_bus_t      ph_bus;
    msosc_pkg::shp_ctl_t     shp_ctl;
    logic [SAMPLE_BITS-1:0]  shp_mag;
    logic signed [15:0]      out_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_sel_reg    <= msosc_pkg::SHAPE_SINE;
            freq_word_reg    <= '0;
            phase_offset_reg <= '0;
            amplitude_reg    <= msosc_pkg::AMPLITUDE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                msosc_pkg::REG_SHAPE:     shape_sel_reg    <= cfg_data[1:0];
                msosc_pkg::REG_FREQ:      freq_word_reg    <= cfg_data;
                msosc_pkg::REG_PHASE:     phase_offset_reg <= cfg_data[15:0];
                msosc_pkg::REG_AMPLITUDE: amplitude_reg    <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // advance while the output register is free or being drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    msosc_phase u_phase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .time_ticks   (s_tdata),
        .freq_word    (freq_word_reg),
        .phase_offset (phase_offset_reg),
        .ph           (ph_bus)
    );

    msosc_shape #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_shape (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .ph           (ph_bus),
        .shape_select (shape_sel_reg),
        .ctl          (shp_ctl),
        .mag          (shp_mag)
    );

    msosc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ctl        (shp_ctl),
        .mag        (shp_mag),
        .amplitude  (amplitude_reg),
        .out_valid  (m_tvalid),
        .out_sample (out_sample)
    );

    assign m_tdata = out_sample;

    `MSOSC_ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `MSOSC_ASSERT_NEXT(a_phase_stage_holds, aclk, aresetn, !adv, $stable(ph_bus))
    `MSOSC_ASSERT_NEXT(a_shape_stage_holds, aclk, aresetn, !adv, $stable(shp_ctl) && $stable(shp_mag))

endmodule
